@@ hdl/kptmm_pkg.sv @@
package kptmm_pkg;

   // Number of table slots, one cell each.
   localparam int DEPTH = 64;

   // What travels down the cell chain with one record.
   typedef struct packed {
      logic        vld;        // record present in this stage
      logic [31:0] key;        // timestamp of the record
      logic [31:0] val;        // price of the record
      logic        placed;     // record has found its slot (hit or insert)
      logic        any;        // at least one held entry folded in so far
      logic [31:0] top_stamp;  // largest timestamp seen so far
      logic [31:0] top_price;  // price at top_stamp
      logic [31:0] hi;         // greatest price seen so far
      logic [31:0] lo;         // least price seen so far
   } kptmm_tok_type;

endpackage

@@ hdl/kptmm_cell.sv @@
module kptmm_cell
   import kptmm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  kptmm_tok_type up_tok,
   output kptmm_tok_type dn_tok,
   output logic          slot_vld
);

   logic          vld_ff, vld_in;
   logic [31:0]   stamp_ff, stamp_in;
   logic [31:0]   price_ff, price_in;
   kptmm_tok_type tok_ff, tok_in;
   logic          match;
   logic          insert;

   always_comb begin
      match    = vld_ff && (stamp_ff == up_tok.key) && !up_tok.placed;
      insert   = !vld_ff && !up_tok.placed;
      vld_in   = vld_ff;
      stamp_in = stamp_ff;
      price_in = price_ff;
      tok_in   = up_tok;
      if (up_tok.vld) begin
         if (match) begin
            price_in      = up_tok.val;
            tok_in.placed = 1'b1;
         end else if (insert) begin
            // first free slot: every held slot lies upstream and was checked
            vld_in        = 1'b1;
            stamp_in      = up_tok.key;
            price_in      = up_tok.val;
            tok_in.placed = 1'b1;
         end
      end
      // fold this slot, as updated, into the running results
      if (vld_in) begin
         if (!up_tok.any) begin
            tok_in.any       = 1'b1;
            tok_in.top_stamp = stamp_in;
            tok_in.top_price = price_in;
            tok_in.hi        = price_in;
            tok_in.lo        = price_in;
         end else begin
            if (stamp_in > up_tok.top_stamp) begin
               tok_in.top_stamp = stamp_in;
               tok_in.top_price = price_in;
            end
            if (price_in > up_tok.hi) begin
               tok_in.hi = price_in;
            end
            if (price_in < up_tok.lo) begin
               tok_in.lo = price_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= 1'b0;
         tok_ff.vld <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_in;
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stamp_ff <= stamp_in;
         price_ff <= price_in;
      end
   end

   assign dn_tok   = tok_ff;
   assign slot_vld = vld_ff;

endmodule

@@ hdl/keyed_price_table_min_max.sv @@
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_stamp, req_price
// rsp       out        rsp_valid/rsp_stall  rsp_latest_price, rsp_max_price,
//                                           rsp_min_price, rsp_table_full
//
// One record is taken per cycle while req_stall is low; records follow each
// other down a chain of DEPTH cells, one cell per cycle while not frozen, so a
// result passes through DEPTH cell stages plus the output register.
// Reset clears the slot valid bits and the chain; no clearing pass is needed.
// A held result with rsp_stall high freezes the whole chain and raises req_stall.
module keyed_price_table_min_max
   import kptmm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_stamp,
   input  logic [31:0] req_price,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_latest_price,
   output logic [31:0] rsp_max_price,
   output logic [31:0] rsp_min_price,
   output logic        rsp_table_full
);

   kptmm_tok_type          chain [DEPTH+1];
   logic [DEPTH-1:0]       slot_vld;
   logic                   en;
   logic                   rsp_valid_ff;
   logic [31:0]            latest_ff, max_ff, min_ff;
   logic                   full_ff;

   // advance everything unless a finished result is held
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_comb begin
      chain[0]           = '0;
      chain[0].vld       = req_valid && en;
      chain[0].key       = req_stamp;
      chain[0].val       = req_price;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      kptmm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .up_tok   (chain[i]),
         .dn_tok   (chain[i+1]),
         .slot_vld (slot_vld[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= chain[DEPTH].vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en && chain[DEPTH].vld) begin
         latest_ff <= chain[DEPTH].top_price;
         max_ff    <= chain[DEPTH].hi;
         min_ff    <= chain[DEPTH].lo;
         full_ff   <= !chain[DEPTH].placed;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_latest_price = latest_ff;
   assign rsp_max_price    = max_ff;
   assign rsp_min_price    = min_ff;
   assign rsp_table_full   = full_ff;

   // held slots always form a prefix of the chain
   a_prefix: assert property (@(posedge clock) disable iff (reset)
      ((slot_vld >> 1) & ~slot_vld) == '0)
      else $error("slot valid bits are not a prefix");

   // a dropped record only when every slot is held
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      en && chain[DEPTH].vld && !chain[DEPTH].placed |-> &slot_vld)
      else $error("record dropped while a slot is free");

   // a record leaving the chain has seen at least one held entry
   a_any: assert property (@(posedge clock) disable iff (reset)
      chain[DEPTH].vld |-> chain[DEPTH].any)
      else $error("result without any held entry");

   // least price never exceeds greatest price
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (min_ff <= max_ff))
      else $error("min price above max price");

endmodule
